>>> rtl/tlmr_pkg.sv
// Shared types and constants for the two-wire LED matrix receiver.
// Used by the bus decoder and by the top level; depends on nothing.
package tlmr_pkg;

  // Display RAM size and field widths.
  localparam int TLMR_RAM_COLUMNS = 16;
  localparam int TLMR_COL_W       = 4;
  localparam int TLMR_BYTE_W      = 8;
  localparam int TLMR_PULSE_W     = 3;

  // Command class, taken from bits 7:6 of the first byte of a frame.
  typedef enum logic [1:0] {
    CMD_UNKNOWN   = 2'b00,
    CMD_DATA_MODE = 2'b01,
    CMD_DISP_CTRL = 2'b10,
    CMD_ADDRESS   = 2'b11
  } cmd_t;

  // Bit positions inside a command byte.
  localparam int CMD_FIXED_BIT  = 2;
  localparam int CMD_ENABLE_BIT = 3;

  // Outcome of one pin sample, handed from the decoder to the top level.
  typedef struct packed {
    logic                    wr_en;
    logic [TLMR_COL_W-1:0]   wr_addr;
    logic [TLMR_BYTE_W-1:0]  wr_data;
    logic                    err;
    logic                    disp_on;
    logic [TLMR_PULSE_W-1:0] pulse;
  } step_res_t;

endpackage

>>> rtl/tlmr_bus_decode.sv
// Serial bus decoder: start/stop detection, bit shifting and command handling.
// Depends on tlmr_pkg; the display RAM itself lives in the top level.
module tlmr_bus_decode import tlmr_pkg::*; #(
  parameter int RAM_COLUMNS = TLMR_RAM_COLUMNS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      clk_req,
  input  logic      dio,
  output step_res_t res
);

  // Bus state registers.
  logic                    prev_clk, prev_clk_next;
  logic                    prev_dio, prev_dio_next;
  logic                    in_frame, in_frame_next;
  logic [TLMR_BYTE_W-1:0]  shift_byte, shift_byte_next;
  logic [TLMR_COL_W-1:0]   bit_count, bit_count_next;
  logic                    expect_command, expect_command_next;
  logic                    data_allowed, data_allowed_next;
  logic                    fixed_mode, fixed_mode_next;
  logic [TLMR_COL_W-1:0]   column_addr, column_addr_next;
  logic                    enable_flag, enable_flag_next;
  logic [TLMR_PULSE_W-1:0] pulse_code, pulse_code_next;

  logic                    start_cond;
  logic                    stop_cond;
  logic                    bit_rise;
  logic [TLMR_BYTE_W-1:0]  shifted;
  logic [TLMR_COL_W-1:0]   count_inc;
  logic                    col_in_range;
  cmd_t                    cmd;

  // Bus conditions seen between the previous sample and this one.
  assign start_cond   = prev_clk && clk_req && prev_dio && !dio;
  assign stop_cond    = prev_clk && clk_req && !prev_dio && dio;
  assign bit_rise     = !prev_clk && clk_req && in_frame;
  assign shifted      = {dio, shift_byte[TLMR_BYTE_W-1:1]};
  assign count_inc    = bit_count + TLMR_COL_W'(1);
  assign col_in_range = {1'b0, column_addr} < (TLMR_COL_W + 1)'(RAM_COLUMNS);
  assign cmd          = cmd_t'(shifted[TLMR_BYTE_W-1 -: 2]);

  // Next state and the result of this sample.
  always_comb begin
    prev_clk_next       = clk_req;
    prev_dio_next       = dio;
    in_frame_next       = in_frame;
    shift_byte_next     = shift_byte;
    bit_count_next      = bit_count;
    expect_command_next = expect_command;
    data_allowed_next   = data_allowed;
    fixed_mode_next     = fixed_mode;
    column_addr_next    = column_addr;
    enable_flag_next    = enable_flag;
    pulse_code_next     = pulse_code;
    res.wr_en           = 1'b0;
    res.wr_addr         = '0;
    res.wr_data         = '0;
    res.err             = 1'b0;

    if (start_cond || stop_cond) begin
      // A start opens a frame and a stop closes it; both drop the partial byte.
      in_frame_next       = start_cond;
      shift_byte_next     = '0;
      bit_count_next      = '0;
      expect_command_next = 1'b1;
      data_allowed_next   = 1'b0;
    end else if (bit_rise) begin
      shift_byte_next = shifted;
      bit_count_next  = count_inc;
      if (count_inc[TLMR_COL_W-1]) begin
        // Eighth bit: the byte is complete.
        shift_byte_next = '0;
        bit_count_next  = '0;
        if (expect_command) begin
          expect_command_next = 1'b0;
          data_allowed_next   = 1'b0;
          case (cmd)
            CMD_DATA_MODE: begin
              fixed_mode_next = shifted[CMD_FIXED_BIT];
            end
            CMD_ADDRESS: begin
              column_addr_next  = shifted[TLMR_COL_W-1:0];
              data_allowed_next = 1'b1;
            end
            CMD_DISP_CTRL: begin
              enable_flag_next = shifted[CMD_ENABLE_BIT];
              pulse_code_next  = shifted[TLMR_PULSE_W-1:0];
            end
            default: begin
              res.err = 1'b1;
            end
          endcase
        end else if (data_allowed) begin
          // Data byte; past-RAM columns are skipped but advance unless fixed.
          if (col_in_range) begin
            res.wr_en   = 1'b1;
            res.wr_addr = column_addr;
            res.wr_data = shifted;
          end
          if (!fixed_mode) begin
            column_addr_next = column_addr + TLMR_COL_W'(1);
          end
        end else begin
          res.err = 1'b1;
        end
      end
    end

    res.disp_on = enable_flag_next;
    res.pulse   = pulse_code_next;
  end

  // State update, one sample per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_clk       <= 1'b1;
      prev_dio       <= 1'b1;
      in_frame       <= 1'b0;
      shift_byte     <= '0;
      bit_count      <= '0;
      expect_command <= 1'b1;
      data_allowed   <= 1'b0;
      fixed_mode     <= 1'b0;
      column_addr    <= '0;
      enable_flag    <= 1'b0;
      pulse_code     <= '0;
    end else if (step) begin
      prev_clk       <= prev_clk_next;
      prev_dio       <= prev_dio_next;
      in_frame       <= in_frame_next;
      shift_byte     <= shift_byte_next;
      bit_count      <= bit_count_next;
      expect_command <= expect_command_next;
      data_allowed   <= data_allowed_next;
      fixed_mode     <= fixed_mode_next;
      column_addr    <= column_addr_next;
      enable_flag    <= enable_flag_next;
      pulse_code     <= pulse_code_next;
    end
  end

`ifndef SYNTHESIS
  // The bit counter is cleared on the eighth bit, so it never holds eight.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= TLMR_COL_W'(7))
    else $error("bit counter out of range");

  // Outside a frame no partial byte is kept.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (bit_count == '0 && shift_byte == '0))
    else $error("partial byte held outside a frame");

  // A finished byte is never both written and flagged.
  a_write_or_error: assert property (@(posedge clk) disable iff (rst)
    !(res.wr_en && res.err))
    else $error("write and error on the same byte");
`endif

endmodule

>>> rtl/two_wire_led_matrix_receiver_top.sv
// Latency: a result word appears in the cycle after its sample word is accepted.
// Throughput: one sample word per cycle unless stalled; the RAM does one read and
// at most one write per accepted word; same-cycle writes go to the scan read.
// Reset clears all bus state and the per-column valid bits, so the RAM reads
// as zeros from the first accepted word on; no clearing pass is needed.
// Depends on tlmr_pkg and tlmr_bus_decode.
module two_wire_led_matrix_receiver_top import tlmr_pkg::*; #(
  parameter int RAM_COLUMNS = TLMR_RAM_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    clk_req,
  input  logic                    dio,
  input  logic [TLMR_COL_W-1:0]   scan_col,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    write_valid,
  output logic [TLMR_COL_W-1:0]   write_addr,
  output logic [TLMR_BYTE_W-1:0]  write_data,
  output logic                    display_on,
  output logic [TLMR_PULSE_W-1:0] pulse_level,
  output logic [TLMR_BYTE_W-1:0]  scan_data,
  output logic                    bus_error
);

  localparam int AW = (RAM_COLUMNS > 1) ? $clog2(RAM_COLUMNS) : 1;

  logic                   accept;
  step_res_t              res;
  logic                   scan_in_range;
  logic [AW-1:0]          scan_idx;
  logic [AW-1:0]          wr_idx;
  logic [TLMR_BYTE_W-1:0] ram [RAM_COLUMNS];
  logic [RAM_COLUMNS-1:0] ram_vld;
  logic [TLMR_BYTE_W-1:0] rd_data;
  logic                   rd_hit;
  logic                   fwd_hit;

  // The output register frees the input side whenever it is empty or moving.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  tlmr_bus_decode #(
    .RAM_COLUMNS(RAM_COLUMNS)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .clk_req (clk_req),
    .dio     (dio),
    .res     (res)
  );

  assign scan_in_range = {1'b0, scan_col} < (TLMR_COL_W + 1)'(RAM_COLUMNS);
  assign scan_idx      = scan_col[AW-1:0];
  assign wr_idx        = res.wr_addr[AW-1:0];

  // Display RAM: one registered read and at most one write per accepted word.
  always_ff @(posedge clk) begin
    if (accept && res.wr_en) begin
      ram[wr_idx] <= res.wr_data;
    end
    if (accept) begin
      rd_data <= ram[scan_idx];
    end
  end

  // Per-column valid bits; a column never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_vld <= '0;
    end else if (accept && res.wr_en) begin
      ram_vld[wr_idx] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      write_valid <= res.wr_en;
      write_addr  <= res.wr_addr;
      write_data  <= res.wr_data;
      display_on  <= res.disp_on;
      pulse_level <= res.pulse;
      bus_error   <= res.err;
      rd_hit      <= scan_in_range && ram_vld[scan_idx];
      fwd_hit     <= res.wr_en && (res.wr_addr == scan_col);
    end
  end

  // The scan read sees the old entry, so a write to the same column is forwarded.
  assign scan_data = fwd_hit ? write_data : (rd_hit ? rd_data : '0);

`ifndef SYNTHESIS
  // Every accepted word yields a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  // A RAM write lands at the column reported on the output.
  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && res.wr_en) |=> (ram[$past(wr_idx)] == write_data && write_valid))
    else $error("RAM write lost");

  // A forwarded scan read only happens together with a write.
  a_fwd_needs_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fwd_hit) |-> write_valid)
    else $error("forwarding without a write");
`endif

endmodule
